// ----- rtl/core/mbp_pkg.sv -----
// Shared types and constants for the MSB-first bit packer.
package mbp_pkg;

    localparam int unsigned BYTE_BITS  = 8;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned HELD_W     = 3;
    localparam int unsigned BUF_W      = 15;
    localparam int unsigned TOTAL_W    = 32;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_FLUSH  = 2'd1,
        REQ_START  = 2'd2,
        REQ_NONE   = 2'd3
    } req_kind_t;

    typedef struct packed {
        req_kind_t   req_type;
        logic [7:0]  code_bits;
        logic [3:0]  code_length;
    } req_item_t;

    typedef struct packed {
        logic                byte_valid;
        logic [7:0]          packed_byte;
        logic [TOTAL_W-1:0]  total_bits;
    } res_item_t;

endpackage

// ----- rtl/core/mbp_in_stage.sv -----
// Input register stage that holds one request and tells upstream when it is full.
module mbp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  mbp_pkg::req_item_t req_in,
    input  logic               take,
    output logic               item_valid,
    output mbp_pkg::req_item_t item
);
    import mbp_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    req_item_t item_reg;
    logic      accept;

    assign req_stall  = vld_reg && !take;
    assign accept     = req_valid && !req_stall;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req_in;
        end
    end

endmodule

// ----- rtl/core/mbp_pack_unit.sv -----
// Packing state and the single-pass update that turns one request into one result.
module mbp_pack_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               update,
    input  mbp_pkg::req_item_t item,
    output mbp_pkg::res_item_t result
);
    import mbp_pkg::*;

    logic [HELD_W-1:0]    held_reg;
    logic [HELD_W-1:0]    held_next;
    logic [BYTE_BITS-2:0] pend_reg;
    logic [BYTE_BITS-2:0] pend_next;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;

    logic [CNT_W-1:0]     len_sat;
    logic [7:0]           code_mask;
    logic [BUF_W-1:0]     buf_val;
    logic [CNT_W-1:0]     cnt_sum;
    logic [CNT_W-1:0]     cnt_left;
    logic [CNT_W-1:0]     free_cnt;
    logic [BUF_W-1:0]     left_mask;
    logic [BUF_W-1:0]     app_byte;
    logic [BUF_W-1:0]     kept;
    logic [BUF_W-1:0]     flush_shift;

    always_comb
    begin
        len_sat     = (item.code_length > CNT_W'(BYTE_BITS)) ? CNT_W'(BYTE_BITS)
                                                             : item.code_length;
        code_mask   = 8'((9'd1 << len_sat) - 9'd1);
        buf_val     = (BUF_W'(pend_reg) << len_sat) | BUF_W'(item.code_bits & code_mask);
        cnt_sum     = CNT_W'(held_reg) + len_sat;
        cnt_left    = (cnt_sum >= CNT_W'(BYTE_BITS)) ? cnt_sum - CNT_W'(BYTE_BITS) : cnt_sum;
        left_mask   = (BUF_W'(1) << cnt_left) - BUF_W'(1);
        app_byte    = buf_val >> cnt_left;
        kept        = buf_val & left_mask;
        free_cnt    = CNT_W'(BYTE_BITS) - CNT_W'(held_reg);
        flush_shift = BUF_W'(pend_reg) << free_cnt;
    end

    always_comb
    begin
        held_next          = held_reg;
        pend_next          = pend_reg;
        total_next         = total_reg;
        result.byte_valid  = 1'b0;
        result.packed_byte = 8'd0;
        unique case (item.req_type)
            REQ_APPEND:
            begin
                if (len_sat != '0)
                begin
                    if (cnt_sum >= CNT_W'(BYTE_BITS))
                    begin
                        result.byte_valid  = 1'b1;
                        result.packed_byte = app_byte[7:0];
                    end
                    pend_next  = kept[BYTE_BITS-2:0];
                    held_next  = cnt_left[HELD_W-1:0];
                    total_next = total_reg + TOTAL_W'(len_sat);
                end
            end
            REQ_FLUSH:
            begin
                if (held_reg != '0)
                begin
                    result.byte_valid  = 1'b1;
                    result.packed_byte = flush_shift[7:0];
                    total_next         = total_reg + TOTAL_W'(free_cnt);
                    pend_next          = '0;
                    held_next          = '0;
                end
            end
            REQ_START:
            begin
                pend_next  = '0;
                held_next  = '0;
                total_next = '0;
            end
            REQ_NONE:
            begin
                held_next = held_reg;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
        result.total_bits = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            pend_reg  <= '0;
            total_reg <= '0;
        end
        else if (update)
        begin
            held_reg  <= held_next;
            pend_reg  <= pend_next;
            total_reg <= total_next;
        end
    end

endmodule

// ----- rtl/core/mbp_out_stage.sv -----
// Result register that holds one finished result until downstream takes it.
module mbp_out_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  mbp_pkg::res_item_t                result,
    output logic                              take,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic                              byte_valid,
    output logic [7:0]                        packed_byte,
    output logic [mbp_pkg::TOTAL_W-1:0]       total_bits
);
    import mbp_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    res_item_t res_reg;

    assign take        = item_valid && (!vld_reg || !res_stall);
    assign res_valid   = vld_reg;
    assign byte_valid  = res_reg.byte_valid;
    assign packed_byte = res_reg.packed_byte;
    assign total_bits  = res_reg.total_bits;

    always_comb
    begin
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (!res_stall)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= result;
        end
    end

endmodule

// ----- rtl/core/msb_first_bit_packer.sv -----
// Top level of the MSB-first variable-length bit packer.
// The packer takes one request per cycle while downstream does not stall and returns
// exactly one result per request. A request is held in an input register; the packing
// update (a shift, a mask and a 4-bit compare against the pending bit count) runs in
// one pass from that register into the result register, so throughput is one transfer
// per cycle and is bounded only by downstream stall. Append requests use the low
// code_length bits (lengths above eight count as eight, zero appends nothing); a flush
// pads the partial byte with zeros; start clears the pending bits and the running bit
// count.
module msb_first_bit_packer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    req_type,
    input  logic [7:0]                    code_bits,
    input  logic [3:0]                    code_length,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic                          byte_valid,
    output logic [7:0]                    packed_byte,
    output logic [mbp_pkg::TOTAL_W-1:0]   total_bits
);
    import mbp_pkg::*;

    req_item_t req_in;
    req_item_t item;
    res_item_t result;
    logic      item_valid;
    logic      take;

    always_comb
    begin
        req_in.req_type    = req_kind_t'(req_type);
        req_in.code_bits   = code_bits;
        req_in.code_length = code_length;
    end

    mbp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_in     (req_in),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    mbp_pack_unit u_pack_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (take),
        .item   (item),
        .result (result)
    );

    mbp_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .result      (result),
        .take        (take),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .byte_valid  (byte_valid),
        .packed_byte (packed_byte),
        .total_bits  (total_bits)
    );

endmodule

// ----- rtl/core/mbp_checker.sv -----
// Port-level checks for the bit packer and the bind that attaches them.
module mbp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_stall,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic        byte_valid,
    input  logic [7:0]  packed_byte,
    input  logic [31:0] total_bits
);

    // Upstream is only held off when the result register is full and stalled.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (res_valid && res_stall))
        else $error("request stall while the result path can drain");

    // A result without a byte carries a zero byte.
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !byte_valid) |-> (packed_byte == 8'd0))
        else $error("nonzero packed byte without byte_valid");

    // A stalled result holds its fields.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=>
            (res_valid && $stable(byte_valid) && $stable(packed_byte)
             && $stable(total_bits)))
        else $error("stalled result changed");

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_stall   (req_stall),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .byte_valid  (byte_valid),
    .packed_byte (packed_byte),
    .total_bits  (total_bits)
);
